/* hdl/scfp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Serial command frame parser package
// Shared types and constants for the frame parser: byte codes, widths,
// reset values and the structs passed between modules.
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int ByteW     = 8;
  localparam int IdxW      = 4;
  localparam int SlotCount = 5;

  localparam logic [ByteW-1:0] StartByte    = 8'h2A;  // '*'
  localparam logic [ByteW-1:0] CmdData      = 8'h25;  // '%'
  localparam logic [ByteW-1:0] CmdAddr      = 8'h24;  // '$'
  localparam logic [ByteW-1:0] Slot0Reset   = 8'h7E;
  localparam logic [ByteW-1:0] TimeoutReset = 8'd50;
  localparam logic [ByteW-1:0] CounterReset = 8'd100;
  localparam logic [IdxW-1:0]  LastIndex    = 4'd8;
  localparam logic [IdxW-1:0]  MinTakeIndex = 4'd3;

  typedef enum logic {
    OpByte = 1'b0,
    OpTick = 1'b1
  } op_t;

  typedef enum logic {
    KindData = 1'b0,
    KindAddr = 1'b1
  } kind_t;

  typedef struct packed {
    op_t              operation;
    logic [ByteW-1:0] byte_value;
  } item_t;

  typedef struct packed {
    kind_t            frame_kind;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] command_byte;
    logic [ByteW-1:0] address_byte;
  } result_t;

  typedef struct packed {
    logic            res_valid;
    logic [IdxW-1:0] write_index;
  } core_status_t;

endpackage
`default_nettype wire

/* hdl/scfp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame parser stream interfaces
// Valid/ready channels for incoming items and outgoing transmit requests.
// ----------------------------------------------------------------------------
interface scfp_cmd_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] byte_value;

  modport source (output valid, output operation, output byte_value, input ready);
  modport sink   (input valid, input operation, input byte_value, output ready);
endinterface

interface scfp_req_if;
  logic       valid;
  logic       ready;
  logic       frame_kind;
  logic [7:0] data_byte;
  logic [7:0] command_byte;
  logic [7:0] address_byte;

  modport source (output valid, output frame_kind, output data_byte,
                  output command_byte, output address_byte, input ready);
  modport sink   (input valid, input frame_kind, input data_byte,
                  input command_byte, input address_byte, output ready);
endinterface
`default_nettype wire

/* hdl/serial_command_frame_parser_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Serial command frame parser
// Assembles command frames from received serial bytes and, after a period
// of line silence counted in ticks, turns a complete frame into one bus
// transmit request.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                   Transfer
//  cmd       sink       operation, byte_value                     valid & ready
//  req       source     frame_kind, data_byte, command_byte,
//                       address_byte                              valid & ready
//  cfg       write      cfg_wdata (idle_timeout)                  cfg_we
//
// An item waits in the input register, and the frame core updates its state
// at the edge that moves the item on; with req ready a new item is accepted
// every cycle, so the sustained rate is one item per clock. A request shows
// on req once the tick that produced it has moved on from the input register
// and been loaded into the result register. Reset (rst, synchronous) empties
// both registers and sets the frame slots, index, idle counter and timeout to
// their initial values. While the result register holds a request that req
// has not taken, the item in the input register waits, whether or not it
// would produce a request, and cmd ready stays low until req takes it.
//
module serial_command_frame_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  scfp_cmd_if.sink         cmd,
  scfp_req_if.source       req,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  // Input register: one received byte or tick waiting for the core.
  logic                   item_valid;
  scfp_pkg::item_t        item;
  logic                   slot_free;
  logic                   advance;
  scfp_pkg::result_t      result;
  scfp_pkg::core_status_t status;

  // An item moves through the core only when the result register can take
  // whatever it produces, so no request is ever overwritten.
  assign advance   = item_valid && slot_free;
  assign cmd.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.operation  <= scfp_pkg::op_t'(cmd.operation);
      item.byte_value <= cmd.byte_value;
    end
  end

  scfp_frame_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (advance),
    .item       (item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .result     (result),
    .status     (status)
  );

  scfp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_valid (status.res_valid),
    .result    (result),
    .slot_free (slot_free),
    .req       (req)
  );

`ifndef NO_ASSERTIONS
  // The write index never runs past the last frame position.
  assert property (@(posedge clk) disable iff (rst)
    status.write_index <= scfp_pkg::LastIndex)
    else $error("write index beyond last position");

  // Taking a frame always clears the write index.
  assert property (@(posedge clk) disable iff (rst)
    advance && status.res_valid |=> status.write_index == '0)
    else $error("write index not cleared after frame taken");

  // Only a tick can produce a request.
  assert property (@(posedge clk) disable iff (rst)
    status.res_valid |-> item.operation == scfp_pkg::OpTick)
    else $error("request produced by a received byte");

  // While the result register is full and stalled, a waiting item stays put.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !slot_free |=> item_valid && $stable(item))
    else $error("input register changed while stalled");
`endif

endmodule
`default_nettype wire

/* hdl/scfp_frame_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame parser core
// Holds the frame slots, write index, idle counter and timeout register,
// and decodes a buffered frame when a tick finds the line idle.
// ----------------------------------------------------------------------------
module scfp_frame_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  input  wire scfp_pkg::item_t             item,
  input  wire logic                        cfg_we,
  input  wire logic [scfp_pkg::ByteW-1:0]  cfg_wdata,
  output scfp_pkg::result_t                result,
  output scfp_pkg::core_status_t           status
);

  logic [scfp_pkg::ByteW-1:0] slots      [scfp_pkg::SlotCount];
  logic [scfp_pkg::ByteW-1:0] slots_next [scfp_pkg::SlotCount];
  logic [scfp_pkg::IdxW-1:0]  write_index, write_index_next;
  logic [scfp_pkg::ByteW-1:0] idle_counter, idle_counter_next;
  logic [scfp_pkg::ByteW-1:0] idle_timeout;
  logic                       res_valid;

  always_comb begin
    slots_next        = slots;
    write_index_next  = write_index;
    idle_counter_next = idle_counter;
    res_valid         = 1'b0;
    result            = '0;
    if (item_valid) begin
      if (item.operation == scfp_pkg::OpByte) begin
        idle_counter_next = idle_timeout;
        if (item.byte_value == scfp_pkg::StartByte) begin
          write_index_next = '0;
          slots_next[0]    = item.byte_value;
        end else if (write_index < scfp_pkg::LastIndex) begin
          write_index_next = write_index + 1'b1;
          // Bytes beyond the last kept slot advance the index only.
          for (int k = 1; k < scfp_pkg::SlotCount; k++) begin
            if (write_index_next == scfp_pkg::IdxW'(k)) begin
              slots_next[k] = item.byte_value;
            end
          end
        end else begin
          write_index_next = '0;
        end
      end else begin
        if (idle_counter != '0) begin
          idle_counter_next = idle_counter - 1'b1;
        end else if (write_index > scfp_pkg::MinTakeIndex) begin
          write_index_next = '0;
          if (slots[0] == scfp_pkg::StartByte) begin
            result.command_byte = slots[2];
            result.address_byte = slots[3];
            if (slots[1] == scfp_pkg::CmdData) begin
              res_valid         = 1'b1;
              result.frame_kind = scfp_pkg::KindData;
              result.data_byte  = slots[4];
            end else if (slots[1] == scfp_pkg::CmdAddr) begin
              res_valid         = 1'b1;
              result.frame_kind = scfp_pkg::KindAddr;
              result.data_byte  = slots[3];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots[0]     <= scfp_pkg::Slot0Reset;
      for (int k = 1; k < scfp_pkg::SlotCount; k++) begin
        slots[k] <= '0;
      end
      write_index  <= '0;
      idle_counter <= scfp_pkg::CounterReset;
      idle_timeout <= scfp_pkg::TimeoutReset;
    end else begin
      slots        <= slots_next;
      write_index  <= write_index_next;
      idle_counter <= idle_counter_next;
      if (cfg_we) begin
        idle_timeout <= cfg_wdata;
      end
    end
  end

  assign status.res_valid   = res_valid;
  assign status.write_index = write_index;

endmodule
`default_nettype wire

/* hdl/scfp_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame parser result register
// Holds one transmit request until the downstream side takes it.
// ----------------------------------------------------------------------------
module scfp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic              res_valid,
  input  wire scfp_pkg::result_t result,
  output logic                   slot_free,
  scfp_req_if.source             req
);

  logic              valid;
  scfp_pkg::result_t held;

  assign slot_free = !valid || req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load && res_valid) begin
      valid <= 1'b1;
    end else if (req.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      held <= result;
    end
  end

  assign req.valid        = valid;
  assign req.frame_kind   = held.frame_kind;
  assign req.data_byte    = held.data_byte;
  assign req.command_byte = held.command_byte;
  assign req.address_byte = held.address_byte;

endmodule
`default_nettype wire
